[rtl/tscr_pkg.sv]
// Shared types and constants of the scrolling tile-map row renderer.
`timescale 1ns / 1ps
`default_nettype none

package tscr_pkg;

  // Configuration port address width: eight 32-bit registers.
  localparam int unsigned PADDR_W = 5;

  // Largest supported tile size, as a log2.
  localparam logic [2:0] TILE_LOG2_MAX = 3'd5;

  typedef struct packed {
    logic [2:0]  tile_w_log2;
    logic [2:0]  tile_h_log2;
    logic [11:0] screen_left;
    logic [11:0] screen_top;
    logic [11:0] visible_w;
    logic [11:0] visible_h;
    logic [12:0] world_tiles_w;
    logic [12:0] world_tiles_h;
  } tscr_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // request accepted: hold its fields
    logic mem_we;    // request is a map write
    logic calc;      // work out counts, fine offsets and row clipping
    logic base;      // form the first map address
    logic col_adv;   // emit one column and step to the next
    logic ack_load;  // emit a single non-draw result
  } tscr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;     // row outside the visible rows, or no columns
    logic last_col;  // current column is the final one of the row
  } tscr_sts_t;

endpackage

`default_nettype wire

[rtl/tscr_cfg.sv]
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module tscr_cfg
  import tscr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output tscr_cfg_t               cfg_o
);

  localparam logic [2:0] REG_TILE_W_LOG2   = 3'd0;
  localparam logic [2:0] REG_TILE_H_LOG2   = 3'd1;
  localparam logic [2:0] REG_SCREEN_LEFT   = 3'd2;
  localparam logic [2:0] REG_SCREEN_TOP    = 3'd3;
  localparam logic [2:0] REG_VISIBLE_W     = 3'd4;
  localparam logic [2:0] REG_VISIBLE_H     = 3'd5;
  localparam logic [2:0] REG_WORLD_TILES_W = 3'd6;
  localparam logic [2:0] REG_WORLD_TILES_H = 3'd7;

  tscr_cfg_t  cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tile_w_log2   <= 3'd3;
      cfg_q.tile_h_log2   <= 3'd3;
      cfg_q.screen_left   <= 12'd0;
      cfg_q.screen_top    <= 12'd0;
      cfg_q.visible_w     <= 12'd320;
      cfg_q.visible_h     <= 12'd240;
      cfg_q.world_tiles_w <= 13'd64;
      cfg_q.world_tiles_h <= 13'd64;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TILE_W_LOG2:   cfg_q.tile_w_log2   <= pwdata[2:0];
        REG_TILE_H_LOG2:   cfg_q.tile_h_log2   <= pwdata[2:0];
        REG_SCREEN_LEFT:   cfg_q.screen_left   <= pwdata[11:0];
        REG_SCREEN_TOP:    cfg_q.screen_top    <= pwdata[11:0];
        REG_VISIBLE_W:     cfg_q.visible_w     <= pwdata[11:0];
        REG_VISIBLE_H:     cfg_q.visible_h     <= pwdata[11:0];
        REG_WORLD_TILES_W: cfg_q.world_tiles_w <= pwdata[12:0];
        REG_WORLD_TILES_H: cfg_q.world_tiles_h <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TILE_W_LOG2:   prdata = 32'(cfg_q.tile_w_log2);
      REG_TILE_H_LOG2:   prdata = 32'(cfg_q.tile_h_log2);
      REG_SCREEN_LEFT:   prdata = 32'(cfg_q.screen_left);
      REG_SCREEN_TOP:    prdata = 32'(cfg_q.screen_top);
      REG_VISIBLE_W:     prdata = 32'(cfg_q.visible_w);
      REG_VISIBLE_H:     prdata = 32'(cfg_q.visible_h);
      REG_WORLD_TILES_W: prdata = 32'(cfg_q.world_tiles_w);
      REG_WORLD_TILES_H: prdata = 32'(cfg_q.world_tiles_h);
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/tscr_ctrl.sv]
// Controller state machine: sequences map writes and row draws.
`timescale 1ns / 1ps
`default_nettype none

module tscr_ctrl
  import tscr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire logic  op_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  tscr_sts_t  sts_i,
  output tscr_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_BASE = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_ACK  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       out_free;
  logic       out_load;

  assign out_free = !ovalid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.mem_we  = !op_i;
          state_d       = op_i ? S_CALC : S_ACK;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_BASE;
      end
      S_BASE: begin
        cmd_o.base = 1'b1;
        state_d    = sts_i.empty ? S_ACK : S_RUN;
      end
      S_RUN: begin
        if (out_free) begin
          cmd_o.col_adv = 1'b1;
          if (sts_i.last_col) begin
            state_d = S_IDLE;
          end
        end
      end
      S_ACK: begin
        if (out_free) begin
          cmd_o.ack_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_load = cmd_o.col_adv || cmd_o.ack_load;

  always_comb begin
    if (out_load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

`default_nettype wire

[rtl/tscr_dp.sv]
// Datapath: tile map memory, scroll and clip arithmetic, column stepping, result register.
`timescale 1ns / 1ps
`default_nettype none

module tscr_dp
  import tscr_pkg::*;
#(
  parameter int unsigned MAP_DEPTH = 4096,
  parameter int unsigned MAX_COLS  = 64,
  parameter int unsigned MAX_ROWS  = 64
) (
  input  wire logic        clk_i,
  input  tscr_cfg_t        cfg_i,
  input  tscr_cmd_t        cmd_i,
  output tscr_sts_t        sts_o,
  input  wire logic [11:0] map_index_i,
  input  wire logic [15:0] tile_value_i,
  input  wire logic [15:0] camera_x_i,
  input  wire logic [15:0] camera_y_i,
  input  wire logic [5:0]  row_number_i,
  output logic             is_draw_o,
  output logic [12:0]      screen_x_o,
  output logic [12:0]      screen_y_o,
  output logic [4:0]       src_x_o,
  output logic [4:0]       src_y_o,
  output logic [5:0]       clip_w_o,
  output logic [5:0]       clip_h_o,
  output logic [15:0]      tile_id_o,
  output logic             outside_o,
  output logic             last_o
);

  localparam int unsigned AW   = $clog2(MAP_DEPTH);
  localparam int unsigned CNTW = $clog2(MAX_COLS + 1);
  localparam int unsigned IDXW = $clog2(MAX_COLS);

  // Map memory.
  logic [15:0] mem_q [MAP_DEPTH];
  logic [15:0] rdata_q;

  // Captured request.
  logic [15:0] cam_x_q, cam_y_q;
  logic [5:0]  row_q;
  logic        wr_out_q;

  // Row setup results.
  logic [5:0]      size_w_q;
  logic [4:0]      offx_q;
  logic [15:0]     bx_q;
  logic [CNTW-1:0] cols_q;
  logic [5:0]      cw0_q;
  logic [12:0]     sy_q;
  logic [4:0]      srcy_q;
  logic [5:0]      ch_q;
  logic            empty_q;
  logic [29:0]     prod_q;

  // Column stepping.
  logic [IDXW-1:0] col_q;
  logic [30:0]     addr_q;
  logic [12:0]     pos_q;
  logic [12:0]     rem_q;

  // Result register.
  logic        o_draw_q;
  logic [12:0] o_sx_q, o_sy_q;
  logic [4:0]  o_srcx_q, o_srcy_q;
  logic [5:0]  o_cw_q, o_ch_q;
  logic        o_out_q;
  logic        o_last_q;

  // Setup arithmetic.
  logic [2:0]  lw, lh;
  logic [5:0]  size_w, size_h, mask_w, mask_h;
  logic [4:0]  offx, offy;
  logic [15:0] bx, by;
  logic [12:0] cols_raw, rows_raw, cols_cap, rows_cap;
  logic [10:0] rsh;
  logic [12:0] rdiff;
  logic [5:0]  first_w, first_h;
  logic [12:0] sy;
  logic [4:0]  srcy;
  logic [5:0]  ch, cw0;
  logic        empty;

  logic [16:0] widx;
  logic        wr_oor;

  // Current column.
  logic        first_col;
  logic [12:0] col_sx;
  logic [4:0]  col_srcx;
  logic [5:0]  col_cw;
  logic        col_out;
  logic        col_last;

  assign widx   = 17'(map_index_i);
  assign wr_oor = widx >= 17'(MAP_DEPTH);

  always_comb begin
    lw     = (cfg_i.tile_w_log2 > TILE_LOG2_MAX) ? TILE_LOG2_MAX : cfg_i.tile_w_log2;
    lh     = (cfg_i.tile_h_log2 > TILE_LOG2_MAX) ? TILE_LOG2_MAX : cfg_i.tile_h_log2;
    size_w = 6'd1 << lw;
    size_h = 6'd1 << lh;
    mask_w = size_w - 6'd1;
    mask_h = size_h - 6'd1;
    offx   = cam_x_q[4:0] & mask_w[4:0];
    offy   = cam_y_q[4:0] & mask_h[4:0];
    bx     = cam_x_q >> lw;
    by     = cam_y_q >> lh;

    // One extra tile when the window has a partial tile or the view is fine-scrolled.
    cols_raw = 13'(cfg_i.visible_w >> lw)
             + 13'(((cfg_i.visible_w[4:0] & mask_w[4:0]) != 5'd0) || (offx != 5'd0));
    rows_raw = 13'(cfg_i.visible_h >> lh)
             + 13'(((cfg_i.visible_h[4:0] & mask_h[4:0]) != 5'd0) || (offy != 5'd0));
    cols_cap = (cols_raw > cfg_i.world_tiles_w) ? cfg_i.world_tiles_w : cols_raw;
    cols_cap = (cols_cap > 13'(MAX_COLS)) ? 13'(MAX_COLS) : cols_cap;
    rows_cap = (rows_raw > cfg_i.world_tiles_h) ? cfg_i.world_tiles_h : rows_raw;
    rows_cap = (rows_cap > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : rows_cap;
    empty    = (13'(row_q) >= rows_cap) || (cols_cap == 13'd0);

    // First tile loses the fine offset and never passes the far window edge.
    first_w = size_w - 6'(offx);
    first_h = size_h - 6'(offy);
    cw0     = (12'(first_w) > cfg_i.visible_w) ? 6'(cfg_i.visible_w) : first_w;

    rsh   = 11'(row_q) << lh;
    rdiff = 13'(cfg_i.visible_h) + 13'(offy) - 13'(rsh);
    if (row_q == 6'd0) begin
      sy   = 13'(cfg_i.screen_top);
      srcy = offy;
      ch   = (12'(first_h) > cfg_i.visible_h) ? 6'(cfg_i.visible_h) : first_h;
    end else begin
      sy   = 13'(cfg_i.screen_top) - 13'(offy) + 13'(rsh);
      srcy = 5'd0;
      ch   = (rdiff < 13'(size_h)) ? 6'(rdiff) : size_h;
    end
  end

  always_comb begin
    first_col = col_q == '0;
    col_sx    = first_col ? 13'(cfg_i.screen_left) : pos_q;
    col_srcx  = first_col ? offx_q : 5'd0;
    if (first_col) begin
      col_cw = cw0_q;
    end else begin
      col_cw = (rem_q < 13'(size_w_q)) ? 6'(rem_q) : size_w_q;
    end
    col_out  = addr_q >= 31'(MAP_DEPTH);
    col_last = (CNTW'(col_q) + CNTW'(1)) == cols_q;
  end

  assign sts_o.empty    = empty_q;
  assign sts_o.last_col = col_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we && !wr_oor) begin
      mem_q[widx[AW-1:0]] <= tile_value_i;
    end
    if (cmd_i.col_adv) begin
      rdata_q <= mem_q[addr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cam_x_q  <= camera_x_i;
      cam_y_q  <= camera_y_i;
      row_q    <= row_number_i;
      wr_out_q <= cmd_i.mem_we && wr_oor;
    end

    if (cmd_i.calc) begin
      size_w_q <= size_w;
      offx_q   <= offx;
      bx_q     <= bx;
      cols_q   <= CNTW'(cols_cap);
      cw0_q    <= cw0;
      sy_q     <= sy;
      srcy_q   <= srcy;
      ch_q     <= ch;
      empty_q  <= empty;
      prod_q   <= 30'((17'(row_q) + 17'(by)) * 17'(cfg_i.world_tiles_w));
      col_q    <= '0;
      pos_q    <= 13'(cfg_i.screen_left) - 13'(offx);
      rem_q    <= 13'(cfg_i.visible_w) + 13'(offx);
    end

    if (cmd_i.base) begin
      addr_q <= 31'(prod_q) + 31'(bx_q);
    end

    // Step the column counters by one tile.
    if (cmd_i.col_adv) begin
      col_q  <= col_q + IDXW'(1);
      addr_q <= addr_q + 31'd1;
      pos_q  <= pos_q + 13'(size_w_q);
      rem_q  <= rem_q - 13'(size_w_q);
    end

    if (cmd_i.col_adv) begin
      o_draw_q <= 1'b1;
      o_sx_q   <= col_sx;
      o_sy_q   <= sy_q;
      o_srcx_q <= col_srcx;
      o_srcy_q <= srcy_q;
      o_cw_q   <= col_cw;
      o_ch_q   <= ch_q;
      o_out_q  <= col_out;
      o_last_q <= col_last;
    end else if (cmd_i.ack_load) begin
      o_draw_q <= 1'b0;
      o_sx_q   <= 13'd0;
      o_sy_q   <= 13'd0;
      o_srcx_q <= 5'd0;
      o_srcy_q <= 5'd0;
      o_cw_q   <= 6'd0;
      o_ch_q   <= 6'd0;
      o_out_q  <= wr_out_q;
      o_last_q <= 1'b1;
    end
  end

  assign is_draw_o  = o_draw_q;
  assign screen_x_o = o_sx_q;
  assign screen_y_o = o_sy_q;
  assign src_x_o    = o_srcx_q;
  assign src_y_o    = o_srcy_q;
  assign clip_w_o   = o_cw_q;
  assign clip_h_o   = o_ch_q;
  assign tile_id_o  = (o_draw_q && !o_out_q) ? rdata_q : 16'd0;
  assign outside_o  = o_out_q;
  assign last_o     = o_last_q;

endmodule

`default_nettype wire

[rtl/tilemap_scroll_clip_row.sv]
// Top level of the scrolling tile-map row renderer.
`timescale 1ns / 1ps
`default_nettype none

// Scrolling tile-map row renderer. A write request (op 0) stores one tile number
// in the map and returns one acknowledge result (is_draw 0, last 1, outside set
// when the index is beyond the map). A draw request (op 1) returns one blit
// command per visible column of the given row, with last on the final one, or a
// single non-draw result when the row is empty. A write is accepted in the idle
// state and its result is loaded from the acknowledge state; a row passes the
// setup steps (accept, count/clip/multiply, base address) and then emits its
// columns, at most MAX_COLS. The column rate, one column per cycle while the
// output is not stalled, is set by the single read port of the map memory, one
// read per column; a stalled output holds the column sequencer. One request is in
// work at a time. There is no clearing pass: map entries read before they are
// written return undefined tile numbers.
module tilemap_scroll_clip_row
  import tscr_pkg::*;
#(
  parameter int unsigned MAP_DEPTH = 4096,
  parameter int unsigned MAX_COLS  = 64,
  parameter int unsigned MAX_ROWS  = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,

  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               op_i,
  input  wire logic [11:0]        map_index_i,
  input  wire logic [15:0]        tile_value_i,
  input  wire logic [15:0]        camera_x_i,
  input  wire logic [15:0]        camera_y_i,
  input  wire logic [5:0]         row_number_i,

  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    is_draw_o,
  output logic [12:0]             screen_x_o,
  output logic [12:0]             screen_y_o,
  output logic [4:0]              src_x_o,
  output logic [4:0]              src_y_o,
  output logic [5:0]              clip_w_o,
  output logic [5:0]              clip_h_o,
  output logic [15:0]             tile_id_o,
  output logic                    outside_o,
  output logic                    last_o
);

  tscr_cfg_t cfg;
  tscr_cmd_t cmd;
  tscr_sts_t sts;

  assign pready = 1'b1;

  tscr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  tscr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tscr_dp #(
    .MAP_DEPTH (MAP_DEPTH),
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .map_index_i  (map_index_i),
    .tile_value_i (tile_value_i),
    .camera_x_i   (camera_x_i),
    .camera_y_i   (camera_y_i),
    .row_number_i (row_number_i),
    .is_draw_o    (is_draw_o),
    .screen_x_o   (screen_x_o),
    .screen_y_o   (screen_y_o),
    .src_x_o      (src_x_o),
    .src_y_o      (src_y_o),
    .clip_w_o     (clip_w_o),
    .clip_h_o     (clip_h_o),
    .tile_id_o    (tile_id_o),
    .outside_o    (outside_o),
    .last_o       (last_o)
  );

  // A non-draw result is always a lone, blank result.
  a_ack_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_draw_o |->
      last_o && screen_x_o == 13'd0 && clip_w_o == 6'd0 && tile_id_o == 16'd0)
    else $error("non-draw result not blank");

  // An out-of-map column never carries a tile number.
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outside_o |-> tile_id_o == 16'd0)
    else $error("outside result with nonzero tile");

  // No new request is taken while a row is still being emitted.
  a_no_accept_mid_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_draw_o && !last_o |-> !in_ready_o)
    else $error("request accepted in the middle of a row");

endmodule

`default_nettype wire
